// File: rtl/core/dipm_pkg.sv
// ----------------------------------------------------------------------------
// dipm_pkg
// Shared types, constants and helpers for the display idle power manager.
// ----------------------------------------------------------------------------
package dipm_pkg;

  localparam int unsigned TIME_W           = 32;
  localparam int unsigned SEQ_W            = 32;
  localparam int unsigned MIN_W            = 8;
  localparam int unsigned STYLE_W          = 4;
  localparam int unsigned INTERVAL_W       = 16;
  localparam int unsigned FRAME_NUM_W      = 16;
  localparam int unsigned FRAME_INDEX_BITS_DEF = 16;

  // 255 minutes in milliseconds fits in 24 bits
  localparam int unsigned THR_W            = 24;
  localparam logic [15:0] MS_PER_MINUTE    = 16'd60000;

  // APB register file
  localparam int unsigned APB_DATA_W       = 32;
  localparam int unsigned APB_ADDR_W       = 5;
  localparam int unsigned REG_IDX_W        = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SAVER_AFTER    = 3'd0,
    REG_DIM_AFTER      = 3'd1,
    REG_OFF_AFTER      = 3'd2,
    REG_SAVER_STYLE    = 3'd3,
    REG_FRAME_INTERVAL = 3'd4
  } reg_idx_t;

  localparam logic [MIN_W-1:0]      SAVER_AFTER_RST    = 8'd5;
  localparam logic [MIN_W-1:0]      DIM_AFTER_RST      = 8'd10;
  localparam logic [MIN_W-1:0]      OFF_AFTER_RST      = 8'd30;
  localparam logic [STYLE_W-1:0]    SAVER_STYLE_RST    = 4'd0;
  localparam logic [INTERVAL_W-1:0] FRAME_INTERVAL_RST = 16'd100;
  localparam logic [STYLE_W-1:0]    SAVER_STYLE_NONE   = 4'd0;

  // Settings seen by the datapath; thresholds are kept in milliseconds
  typedef struct packed {
    logic [THR_W-1:0]      saver_at;
    logic [THR_W-1:0]      dim_at;
    logic [THR_W-1:0]      off_at;
    logic [STYLE_W-1:0]    saver_style;
    logic [INTERVAL_W-1:0] frame_interval;
  } cfg_t;

  // Minutes to milliseconds: one 8x16 constant multiply
  function automatic logic [THR_W-1:0] min_to_ms(input logic [MIN_W-1:0] minutes);
    logic [MIN_W+15:0] prod;
    prod = minutes * MS_PER_MINUTE;
    return prod[THR_W-1:0];
  endfunction

endpackage

// File: rtl/core/dipm_if.sv
// ----------------------------------------------------------------------------
// dipm_if
// Valid/ready channels for tick requests and status results.
// ----------------------------------------------------------------------------
interface dipm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [31:0] activity_seq;
  logic        user_activity;
  logic        transport_stopped;

  modport source (
    output valid, now_ms, activity_seq, user_activity, transport_stopped,
    input  ready
  );
  modport sink (
    input  valid, now_ms, activity_seq, user_activity, transport_stopped,
    output ready
  );
endinterface

interface dipm_out_if;
  logic        valid;
  logic        ready;
  logic        display_on;
  logic        display_dim;
  logic        frame_valid;
  logic [15:0] frame_number;
  logic        suppress_ui;
  logic        redraw_request;

  modport source (
    output valid, display_on, display_dim, frame_valid, frame_number,
           suppress_ui, redraw_request,
    input  ready
  );
  modport sink (
    input  valid, display_on, display_dim, frame_valid, frame_number,
           suppress_ui, redraw_request,
    output ready
  );
endinterface

// File: rtl/core/dipm_regs.sv
// ----------------------------------------------------------------------------
// dipm_regs
// APB register file; converts minute thresholds to milliseconds on write.
// ----------------------------------------------------------------------------
module dipm_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dipm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [dipm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [dipm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output dipm_pkg::cfg_t                     cfg
);
  import dipm_pkg::*;

  logic [MIN_W-1:0]      saver_min_r;
  logic [MIN_W-1:0]      dim_min_r;
  logic [MIN_W-1:0]      off_min_r;
  logic [STYLE_W-1:0]    style_r;
  logic [INTERVAL_W-1:0] interval_r;
  logic [THR_W-1:0]      saver_at_r;
  logic [THR_W-1:0]      dim_at_r;
  logic [THR_W-1:0]      off_at_r;
  logic                  wr_en;
  reg_idx_t              idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saver_min_r <= SAVER_AFTER_RST;
      dim_min_r   <= DIM_AFTER_RST;
      off_min_r   <= OFF_AFTER_RST;
      style_r     <= SAVER_STYLE_RST;
      interval_r  <= FRAME_INTERVAL_RST;
      saver_at_r  <= min_to_ms(SAVER_AFTER_RST);
      dim_at_r    <= min_to_ms(DIM_AFTER_RST);
      off_at_r    <= min_to_ms(OFF_AFTER_RST);
    end else if (wr_en) begin
      case (idx)
        REG_SAVER_AFTER: begin
          saver_min_r <= pwdata[MIN_W-1:0];
          saver_at_r  <= min_to_ms(pwdata[MIN_W-1:0]);
        end
        REG_DIM_AFTER: begin
          dim_min_r <= pwdata[MIN_W-1:0];
          dim_at_r  <= min_to_ms(pwdata[MIN_W-1:0]);
        end
        REG_OFF_AFTER: begin
          off_min_r <= pwdata[MIN_W-1:0];
          off_at_r  <= min_to_ms(pwdata[MIN_W-1:0]);
        end
        REG_SAVER_STYLE:    style_r    <= pwdata[STYLE_W-1:0];
        REG_FRAME_INTERVAL: interval_r <= pwdata[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SAVER_AFTER:    prdata = {{(APB_DATA_W-MIN_W){1'b0}}, saver_min_r};
      REG_DIM_AFTER:      prdata = {{(APB_DATA_W-MIN_W){1'b0}}, dim_min_r};
      REG_OFF_AFTER:      prdata = {{(APB_DATA_W-MIN_W){1'b0}}, off_min_r};
      REG_SAVER_STYLE:    prdata = {{(APB_DATA_W-STYLE_W){1'b0}}, style_r};
      REG_FRAME_INTERVAL: prdata = {{(APB_DATA_W-INTERVAL_W){1'b0}}, interval_r};
      default:            prdata = '0;
    endcase
  end

  assign cfg.saver_at       = saver_at_r;
  assign cfg.dim_at         = dim_at_r;
  assign cfg.off_at         = off_at_r;
  assign cfg.saver_style    = style_r;
  assign cfg.frame_interval = interval_r;

endmodule

// File: rtl/core/display_idle_power_manager_unit.sv
// ----------------------------------------------------------------------------
// display_idle_power_manager_unit
// Panel sleep control: power off, dim and screensaver frames from idle time.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-----------------------------------
//  in_item   | in  | valid/ready            | now_ms, activity_seq,
//            |     |                        | user_activity, transport_stopped
//  out_item  | out | valid/ready            | display_on, display_dim, frame_valid,
//            |     |                        | frame_number, suppress_ui, redraw_request
//  cfg (APB) | in  | psel/penable, pready=1 | five registers at paddr 4*i
//
//  One request per cycle sustained while out_item.ready stays high; a request
//  is taken into the input register, then its result into the result register.
//  The state update sits between the input register and the result register,
//  so each request sees the state left by the one before it.
//  Synchronous active-low reset clears both valid flags and the idle state; no clearing pass is needed.
//  A stalled result holds the result register; the input register still takes
//  a request until it too is full, then in_item.ready drops.
// ----------------------------------------------------------------------------
module display_idle_power_manager_unit #(
  parameter int unsigned FRAME_INDEX_BITS = dipm_pkg::FRAME_INDEX_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  dipm_in_if.sink                            in_item,
  dipm_out_if.source                         out_item,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dipm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [dipm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [dipm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import dipm_pkg::*;

  localparam int unsigned FI_W = FRAME_INDEX_BITS;

  cfg_t cfg;

  dipm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic              in_valid_r;
  logic [TIME_W-1:0] now_r;
  logic [SEQ_W-1:0]  seq_r;
  logic              user_r;
  logic              stopped_r;
  logic              in_fire;
  logic              step_fire;
  logic              out_valid_r;

  // Advance the stage when the result register is empty or being drained
  assign step_fire     = in_valid_r & (~out_valid_r | out_item.ready);
  assign in_item.ready = ~in_valid_r | step_fire;
  assign in_fire       = in_item.valid & in_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (step_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_r     <= in_item.now_ms;
      seq_r     <= in_item.activity_seq;
      user_r    <= in_item.user_activity;
      stopped_r <= in_item.transport_stopped;
    end
  end

  // --------------------------------------------------------------------------
  // Idle state
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] last_act_r,   last_act_nxt;
  logic              started_r,    started_nxt;
  logic              off_r,        off_nxt;
  logic              dim_r,        dim_nxt;
  logic              saver_r,      saver_nxt;
  logic [FI_W-1:0]   frame_cnt_r,  frame_cnt_nxt;
  logic [TIME_W-1:0] last_frame_r, last_frame_nxt;
  logic [SEQ_W-1:0]  last_seq_r,   last_seq_nxt;

  // Results of this step
  logic              redraw_nxt;
  logic              suppress_nxt;
  logic              fvalid_nxt;
  logic [FI_W-1:0]   fnum_nxt;

  // State after the activity check
  logic              act;
  logic [TIME_W-1:0] last_act_a;
  logic              off_a;
  logic              dim_a;
  logic              saver_a;
  logic [FI_W-1:0]   frame_cnt_a;
  logic [TIME_W-1:0] last_frame_a;
  logic [TIME_W-1:0] idle_ms;
  logic [TIME_W-1:0] since_frame;

  always_comb begin
    // Activity: a new sequence number or the user flag wakes the panel
    act          = (seq_r != last_seq_r) | user_r;
    // The first request after reset starts the idle clock, with or without activity
    last_act_a   = (act | ~started_r) ? now_r : last_act_r;
    off_a        = ~act & off_r;
    dim_a        = ~act & dim_r;
    saver_a      = ~act & saver_r;
    frame_cnt_a  = act ? '0 : frame_cnt_r;
    last_frame_a = act ? now_r : last_frame_r;

    idle_ms      = now_r - last_act_a;
    since_frame  = now_r - last_frame_a;

    last_seq_nxt   = seq_r;
    started_nxt    = 1'b1;
    last_act_nxt   = last_act_a;
    off_nxt        = off_a;
    dim_nxt        = dim_a;
    saver_nxt      = saver_a;
    frame_cnt_nxt  = frame_cnt_a;
    last_frame_nxt = last_frame_a;
    redraw_nxt     = act;
    suppress_nxt   = 1'b0;
    fvalid_nxt     = 1'b0;
    fnum_nxt       = '0;

    if (!stopped_r) begin
      // Running transport cancels any sleep state
      if (off_a | dim_a | saver_a) begin
        last_act_nxt   = now_r;
        frame_cnt_nxt  = '0;
        last_frame_nxt = now_r;
        off_nxt        = 1'b0;
        dim_nxt        = 1'b0;
        saver_nxt      = 1'b0;
        redraw_nxt     = 1'b1;
      end
    end else if (idle_ms >= {{(TIME_W-THR_W){1'b0}}, cfg.off_at}) begin
      // Panel off: dim and saver keep their values, no frame
      off_nxt      = 1'b1;
      suppress_nxt = 1'b1;
    end else begin
      dim_nxt = (idle_ms >= {{(TIME_W-THR_W){1'b0}}, cfg.dim_at});
      if ((cfg.saver_style != SAVER_STYLE_NONE) &&
          (idle_ms >= {{(TIME_W-THR_W){1'b0}}, cfg.saver_at})) begin
        saver_nxt    = 1'b1;
        suppress_nxt = 1'b1;
        if (!saver_a ||
            (since_frame >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.frame_interval})) begin
          fvalid_nxt     = 1'b1;
          fnum_nxt       = frame_cnt_a;
          frame_cnt_nxt  = frame_cnt_a + FI_W'(1);
          last_frame_nxt = now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_act_r   <= '0;
      started_r    <= 1'b0;
      off_r        <= 1'b0;
      dim_r        <= 1'b0;
      saver_r      <= 1'b0;
      frame_cnt_r  <= '0;
      last_frame_r <= '0;
      last_seq_r   <= '0;
    end else if (step_fire) begin
      last_act_r   <= last_act_nxt;
      started_r    <= started_nxt;
      off_r        <= off_nxt;
      dim_r        <= dim_nxt;
      saver_r      <= saver_nxt;
      frame_cnt_r  <= frame_cnt_nxt;
      last_frame_r <= last_frame_nxt;
      last_seq_r   <= last_seq_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic                   display_on_r;
  logic                   display_dim_r;
  logic                   fvalid_r;
  logic [FRAME_NUM_W-1:0] fnum_r;
  logic                   suppress_r;
  logic                   redraw_r;
  logic [FI_W+FRAME_NUM_W-1:0] fnum_ext;

  // Zero-extend or truncate the frame index to the port width
  assign fnum_ext = {{FRAME_NUM_W{1'b0}}, fnum_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      display_on_r  <= ~off_nxt;
      display_dim_r <= dim_nxt;
      fvalid_r      <= fvalid_nxt;
      fnum_r        <= fnum_ext[FRAME_NUM_W-1:0];
      suppress_r    <= suppress_nxt;
      redraw_r      <= redraw_nxt;
    end
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.display_on     = display_on_r;
  assign out_item.display_dim    = display_dim_r;
  assign out_item.frame_valid    = fvalid_r;
  assign out_item.frame_number   = fnum_r;
  assign out_item.suppress_ui    = suppress_r;
  assign out_item.redraw_request = redraw_r;

endmodule

// File: rtl/core/dipm_checker.sv
// ----------------------------------------------------------------------------
// dipm_checker
// Port-level checks on the result channel of the idle power manager.
// ----------------------------------------------------------------------------
module dipm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        display_on,
  input logic        display_dim,
  input logic        frame_valid,
  input logic [15:0] frame_number,
  input logic        suppress_ui,
  input logic        redraw_request
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({display_on, display_dim, frame_valid, frame_number,
               suppress_ui, redraw_request}))
    else $error("stalled result changed");

  // Frame number is zero when no frame is drawn
  a_idle_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !frame_valid |-> frame_number == 16'd0)
    else $error("frame number without a frame");

  // A drawn frame means the normal UI is skipped
  a_frame_suppress: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_valid |-> suppress_ui)
    else $error("frame drawn without suppress");

endmodule

bind display_idle_power_manager_unit dipm_checker u_dipm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_item.valid),
  .out_ready      (out_item.ready),
  .display_on     (out_item.display_on),
  .display_dim    (out_item.display_dim),
  .frame_valid    (out_item.frame_valid),
  .frame_number   (out_item.frame_number),
  .suppress_ui    (out_item.suppress_ui),
  .redraw_request (out_item.redraw_request)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for display_idle_power_manager_unit. It sends tick
// requests with random gaps and stalls results at random. A model of the idle
// timers, screensaver framing and wake logic checks every status field, and
// the APB registers are set several times with different thresholds.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [31:0] now_ms;
  logic [31:0] activity_seq;
  logic        user_activity;
  logic        transport_stopped;
} tick_t;

typedef struct packed {
  logic        display_on;
  logic        display_dim;
  logic        frame_valid;
  logic [15:0] frame_number;
  logic        suppress_ui;
  logic        redraw_request;
} status_t;

class panel_status_sb;
  localparam int FRAME_BITS = dipm_pkg::FRAME_INDEX_BITS_DEF;

  logic [7:0]            saver_min, dim_min, off_min;
  logic [3:0]            saver_style;
  logic [15:0]           frame_gap_ms;

  logic [31:0]           last_act_ms, last_frame_ms, last_seq;
  logic                  clock_running, panel_off, panel_dim, saver_on;
  logic [FRAME_BITS-1:0] frame_cnt;

  status_t               pending_status[$];
  int                    mismatches;

  function new();
    saver_min     = dipm_pkg::SAVER_AFTER_RST;
    dim_min       = dipm_pkg::DIM_AFTER_RST;
    off_min       = dipm_pkg::OFF_AFTER_RST;
    saver_style   = dipm_pkg::SAVER_STYLE_RST;
    frame_gap_ms  = dipm_pkg::FRAME_INTERVAL_RST;
    last_act_ms   = '0;
    last_frame_ms = '0;
    last_seq      = '0;
    clock_running = 1'b0;
    panel_off     = 1'b0;
    panel_dim     = 1'b0;
    saver_on      = 1'b0;
    frame_cnt     = '0;
    mismatches    = 0;
  endfunction

  function void set_reg(dipm_pkg::reg_idx_t idx, logic [31:0] value);
    case (idx)
      dipm_pkg::REG_SAVER_AFTER:    saver_min    = value[7:0];
      dipm_pkg::REG_DIM_AFTER:      dim_min      = value[7:0];
      dipm_pkg::REG_OFF_AFTER:      off_min      = value[7:0];
      dipm_pkg::REG_SAVER_STYLE:    saver_style  = value[3:0];
      dipm_pkg::REG_FRAME_INTERVAL: frame_gap_ms = value[15:0];
      default: ;
    endcase
  endfunction

  function void wake(logic [31:0] now);
    last_act_ms   = now;
    clock_running = 1'b1;
    frame_cnt     = '0;
    last_frame_ms = now;
    panel_off     = 1'b0;
    panel_dim     = 1'b0;
    saver_on      = 1'b0;
  endfunction

  // Advance the panel state by one accepted request and queue its status.
  function void note_request(tick_t t);
    logic [31:0] idle, saver_at, dim_at, off_at;
    status_t     s;
    s = '0;
    if (t.activity_seq != last_seq) begin
      last_seq = t.activity_seq;
      wake(t.now_ms);
      s.redraw_request = 1'b1;
    end
    if (t.user_activity) begin
      wake(t.now_ms);
      s.redraw_request = 1'b1;
    end
    if (!clock_running) begin
      last_act_ms   = t.now_ms;
      clock_running = 1'b1;
    end
    if (!t.transport_stopped) begin
      if (panel_off || panel_dim || saver_on) begin
        wake(t.now_ms);
        s.redraw_request = 1'b1;
      end
    end else begin
      idle     = t.now_ms - last_act_ms;
      saver_at = saver_min * dipm_pkg::MS_PER_MINUTE;
      dim_at   = dim_min * dipm_pkg::MS_PER_MINUTE;
      off_at   = off_min * dipm_pkg::MS_PER_MINUTE;
      if (idle >= off_at) begin
        panel_off     = 1'b1;
        s.suppress_ui = 1'b1;
      end else begin
        panel_dim = (idle >= dim_at);
        if (saver_style != dipm_pkg::SAVER_STYLE_NONE && idle >= saver_at) begin
          if (!saver_on || (t.now_ms - last_frame_ms) >= frame_gap_ms) begin
            s.frame_valid  = 1'b1;
            s.frame_number = 16'(frame_cnt);
            frame_cnt      = frame_cnt + 1'b1;
            last_frame_ms  = t.now_ms;
          end
          saver_on      = 1'b1;
          s.suppress_ui = 1'b1;
        end
      end
    end
    s.display_on  = !panel_off;
    s.display_dim = panel_dim;
    pending_status.push_back(s);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(status_t got);
    status_t want;
    if (pending_status.size() == 0) begin
      $error("status with no request pending");
      mismatches++;
      return;
    end
    want = pending_status.pop_front();
    compare_field("display_on", want.display_on, got.display_on);
    compare_field("display_dim", want.display_dim, got.display_dim);
    compare_field("frame_valid", want.frame_valid, got.frame_valid);
    compare_field("frame_number", want.frame_number, got.frame_number);
    compare_field("suppress_ui", want.suppress_ui, got.suppress_ui);
    compare_field("redraw_request", want.redraw_request, got.redraw_request);
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dipm_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int          RANDOM_ITEMS = 85;   // requests per random phase
  localparam int          PHASES       = 8;

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  dipm_in_if  in_ch();
  dipm_out_if out_ch();

  panel_status_sb sb;

  // Idle and stall switches; cleared for one phase to get back-to-back traffic
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;

  // Random walk of time and activity, scaled to the current thresholds
  logic [31:0] cur_ms, cur_seq;
  int unsigned span_ms, gap_ms;
  int unsigned cycles = 0;

  display_idle_power_manager_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Drop ready at random, about 23 percent of the time, while stalls are enabled.
  always @(negedge clk) begin
    out_ch.ready <= !stalls_on || ($urandom_range(0, 99) >= 23);
  end

  // Check every status the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.display_on, out_ch.display_dim, out_ch.frame_valid,
                       out_ch.frame_number, out_ch.suppress_ui,
                       out_ch.redraw_request});
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Send one tick request; enter and leave at a falling edge. Valid stays high
  // on return so that back-to-back requests never toggle it within one step.
  task automatic send_tick(input logic [31:0] now, input logic [31:0] seq,
                           input logic user, input logic stopped);
    tick_t t;
    t = {now, seq, user, stopped};
    while (gaps_on && $urandom_range(0, 99) < 23) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.now_ms            <= now;
    in_ch.activity_seq      <= seq;
    in_ch.user_activity     <= user;
    in_ch.transport_stopped <= stopped;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(t);
    @(negedge clk);
  endtask

  // Hold off new requests until every status has come back, then let the
  // two-stage pipeline settle.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup, access, then psel drops before the next transfer.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Drain, program all five registers, and rescale the random time steps.
  task automatic apply_settings(input logic [7:0] saver_min, input logic [7:0] dim_min,
                                input logic [7:0] off_min, input logic [3:0] style,
                                input logic [15:0] frame_gap);
    int unsigned top;
    wait_drain();
    write_reg(REG_SAVER_AFTER, 32'(saver_min));
    write_reg(REG_DIM_AFTER, 32'(dim_min));
    write_reg(REG_OFF_AFTER, 32'(off_min));
    write_reg(REG_SAVER_STYLE, 32'(style));
    write_reg(REG_FRAME_INTERVAL, 32'(frame_gap));
    top = saver_min;
    if (dim_min > top) top = dim_min;
    if (off_min > top) top = off_min;
    span_ms = top * 60000 + 60000;
    gap_ms  = frame_gap;
  endtask

  initial begin
    int unsigned r, step;
    logic [7:0]  sv_min, dm_min, of_min;
    logic [3:0]  style;
    logic [15:0] frame_gap;
    logic        usr, stp;

    sb           = new();
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.now_ms = '0;
    in_ch.activity_seq      = '0;
    in_ch.user_activity     = 1'b0;
    in_ch.transport_stopped = 1'b0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: saver at 1 min, dim at 2, off at 3, saver on, no frame spacing.
    apply_settings(8'd1, 8'd2, 8'd3, 4'd15, 16'd0);
    // A nonzero sequence on the very first tick counts as activity.
    send_tick(32'd0, 32'h8000_0001, 1'b0, 1'b1);
    // Saver starts; with zero spacing every stopped tick draws a frame.
    send_tick(32'd60000, 32'h8000_0001, 1'b0, 1'b1);
    send_tick(32'd60000, 32'h8000_0001, 1'b0, 1'b1);
    send_tick(32'd120000, 32'h8000_0001, 1'b0, 1'b1);
    // Panel off, then the running transport wakes it.
    send_tick(32'd180000, 32'h8000_0001, 1'b0, 1'b1);
    send_tick(32'd180001, 32'h8000_0001, 1'b0, 1'b0);
    send_tick(32'd240001, 32'h8000_0001, 1'b0, 1'b1);
    send_tick(32'd240002, 32'h8000_0001, 1'b1, 1'b1);
    // Activity at the top of the time range, idle measured across the wrap.
    send_tick(32'hFFFF_FFFF, 32'h7FFF_FFFE, 1'b0, 1'b1);
    send_tick(32'h0001_D4BF, 32'h7FFF_FFFE, 1'b0, 1'b1);
    // Disable the saver while it runs: state stays set, UI is not suppressed.
    wait_drain();
    write_reg(REG_SAVER_STYLE, 32'(SAVER_STYLE_NONE));
    send_tick(32'h0001_D4C0, 32'h7FFF_FFFE, 1'b0, 1'b1);
    send_tick(32'h0001_D4C1, 32'h7FFF_FFFE, 1'b0, 1'b0);
    // Zero thresholds: off at once whenever stopped, even right after activity.
    apply_settings(8'd0, 8'd0, 8'd0, 4'd15, 16'hFFFF);
    send_tick(32'd5, 32'h7FFF_FFFE, 1'b0, 1'b1);
    send_tick(32'd6, 32'h0000_0000, 1'b1, 1'b1);
    send_tick(32'd7, 32'hFFFF_FFFF, 1'b0, 1'b0);

    cur_ms  = 32'd7;
    cur_seq = 32'hFFFF_FFFF;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          sv_min = SAVER_AFTER_RST; dm_min = DIM_AFTER_RST; of_min = OFF_AFTER_RST;
          style = 4'd3; frame_gap = FRAME_INTERVAL_RST;
        end
        1: begin
          sv_min = 8'd0; dm_min = 8'd0; of_min = 8'd0; style = 4'd15; frame_gap = 16'hFFFF;
        end
        2: begin
          sv_min = 8'd255; dm_min = 8'd255; of_min = 8'd255; style = 4'd1; frame_gap = 16'd1;
        end
        default: begin
          sv_min = 8'($urandom_range(0, 4));
          dm_min = 8'($urandom_range(0, 4));
          of_min = 8'($urandom_range(0, 5));
          style  = 4'($urandom_range(0, 15));
          case ($urandom_range(0, 3))
            0:       frame_gap = 16'd1;
            1:       frame_gap = 16'hFFFF;
            2:       frame_gap = 16'($urandom_range(2, 40));
            default: frame_gap = 16'($urandom_range(41, 300));
          endcase
        end
      endcase
      // Run phase 3 with no idling on either side.
      gaps_on   = (p != 3);
      stalls_on = (p != 3);
      apply_settings(sv_min, dm_min, of_min, style, frame_gap);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        // Pause mid-phase until the block has answered everything.
        if (i == RANDOM_ITEMS / 2) wait_drain();
        r = $urandom_range(0, 99);
        if (r < 3)       step = 0;
        else if (r < 40) step = $urandom_range(0, 2 * gap_ms + 2);
        else if (r < 80) step = $urandom_range(0, span_ms / 8);
        else if (r < 96) step = $urandom_range(0, span_ms / 2);
        else             step = $urandom;
        cur_ms = cur_ms + step;
        if ($urandom_range(0, 99) < 3) cur_seq = $urandom;
        usr = ($urandom_range(0, 99) < 3);
        stp = ($urandom_range(0, 99) < 90);
        send_tick(cur_ms, cur_seq, usr, stp);
      end
    end

    wait_drain();
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/dipm_pkg.sv
rtl/core/dipm_if.sv
rtl/core/dipm_regs.sv
rtl/core/display_idle_power_manager_unit.sv
rtl/core/dipm_checker.sv
dv/tb.sv
